FILE: design/lrb_pkg.sv
// lrb_pkg: shared types and constants for the line-dropping log ring buffer
// holds request/response structs, front-to-back queue types and ring sizing
// no dependencies
package lrb_pkg;

	// ring sizing
	localparam int DEPTH   = 4096;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int FILL_W  = 13;
	localparam int LEFT_W  = 16;
	localparam int LINES_W = 16;

	// request kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// byte that closes a log line
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [LINES_W-1:0] LINES_MAX = '1;

	// request payload
	typedef struct packed {
		logic              kind;
		logic [7:0]        byte_in;
		logic [LEFT_W-1:0] bytes_left;
	} req_t;

	// response payload
	typedef struct packed {
		logic [7:0]         byte_out;
		logic               byte_valid;
		logic [LINES_W-1:0] lines_missing;
		logic [FILL_W-1:0]  fill_level;
	} rsp_t;

	// classified request as held in the front queue
	typedef struct packed {
		logic              is_read;
		logic [7:0]        data;
		logic [LEFT_W-1:0] drop_n;
	} cmd_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

	// back end status
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             busy;
	} bstat_t;

endpackage

FILE: design/lrb_front.sv
// lrb_front: accepts requests, classifies them and queues them for the back end
// two-entry queue so request intake stalls independently of the back end
// depends on lrb_pkg
module lrb_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lrb_pkg::req_t req,
	input  logic          pop,
	output lrb_pkg::qhead_t head
);

	lrb_pkg::cmd_t fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       do_pop;
	lrb_pkg::cmd_t cmd_in;

	// classify: a zero drop count is raised to one; the byte is still stored
	always_comb begin
		cmd_in.is_read = (req.kind == lrb_pkg::KIND_READ);
		cmd_in.data    = req.byte_in;
		cmd_in.drop_n  = (req.bytes_left == '0) ? lrb_pkg::LEFT_W'(1) : req.bytes_left;
	end

	assign req_stall  = (cnt_q == 2'd2);
	assign push       = req_valid && !req_stall;
	assign do_pop     = pop && (cnt_q != 2'd0);
	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = fifo_q[rd_ptr_q];

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

FILE: design/lrb_back.sv
// lrb_back: ring store, pointers, line-drop sequencer and response register
// single-port-per-direction memory with registered read data
// depends on lrb_pkg
module lrb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lrb_pkg::qhead_t head,
	output logic            pop,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output lrb_pkg::rsp_t   rsp,
	output lrb_pkg::bstat_t stat
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_DROP,
		S_SCAN_ISSUE,
		S_SCAN_CHECK,
		S_WR
	} state_t;

	state_t state_q;

	logic [7:0] mem [lrb_pkg::DEPTH];
	logic [7:0] rd_data_q;

	logic [lrb_pkg::ADDR_W-1:0]  head_q;
	logic [lrb_pkg::ADDR_W-1:0]  tail_q;
	logic [lrb_pkg::CNT_W-1:0]   count_q;
	logic [lrb_pkg::CNT_W-1:0]   count_nx;
	logic [lrb_pkg::LINES_W-1:0] dropped_q;
	logic [lrb_pkg::LINES_W-1:0] lines_inc;
	logic [lrb_pkg::LINES_W-1:0] lat_lines_q;
	logic [lrb_pkg::LEFT_W-1:0]  drop_n_q;
	logic [7:0]                  cur_byte_q;
	logic                        chk_q;
	logic                        out_valid_q;
	lrb_pkg::rsp_t               out_q;

	logic       out_free;
	logic       start;
	logic       full;
	logic       empty;
	logic       rd_en;
	logic       wr_en;
	logic [7:0] wr_data;
	logic       is_nl;

	function automatic logic [lrb_pkg::ADDR_W-1:0] ring_next(
		input logic [lrb_pkg::ADDR_W-1:0] i
	);
		ring_next = (i == lrb_pkg::ADDR_W'(lrb_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign out_free = !out_valid_q || !rsp_stall;
	assign start    = (state_q == S_IDLE) && head.valid && out_free;
	assign pop      = start;
	assign full     = (count_q == lrb_pkg::CNT_W'(lrb_pkg::DEPTH));
	assign empty    = (count_q == '0);

	// memory strobes per state
	always_comb begin
		rd_en   = 1'b0;
		wr_en   = 1'b0;
		wr_data = head.cmd.data;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					rd_en = head.cmd.is_read && !empty;
					wr_en = !head.cmd.is_read && !full;
				end
			end
			S_DROP: begin
				rd_en = (drop_n_q != '0) && !empty;
			end
			S_SCAN_ISSUE: begin
				rd_en = !empty;
			end
			S_WR: begin
				wr_en   = 1'b1;
				wr_data = cur_byte_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// next fill and newline tally from the byte read last cycle
	always_comb begin
		count_nx = count_q;
		if (rd_en) begin
			count_nx = count_q - 1'b1;
		end else if (wr_en) begin
			count_nx = count_q + 1'b1;
		end
		is_nl     = chk_q && (rd_data_q == lrb_pkg::NEWLINE_BYTE);
		lines_inc = dropped_q;
		if (is_nl && (dropped_q != lrb_pkg::LINES_MAX)) begin
			lines_inc = dropped_q + 1'b1;
		end
	end

	// ring store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[head_q];
		end
	end

	// sequencer, pointers and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			dropped_q   <= '0;
			lat_lines_q <= '0;
			drop_n_q    <= '0;
			cur_byte_q  <= '0;
			chk_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			chk_q     <= rd_en && (state_q != S_IDLE);
			dropped_q <= lines_inc;
			count_q   <= count_nx;
			if (rd_en) begin
				head_q <= ring_next(head_q);
			end
			if (wr_en) begin
				tail_q <= ring_next(tail_q);
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (head.cmd.is_read) begin
							dropped_q   <= '0;
							lat_lines_q <= dropped_q;
							if (!empty) begin
								state_q <= S_RD;
							end else begin
								out_valid_q <= 1'b1;
								out_q       <= '{8'h00, 1'b0, dropped_q,
									lrb_pkg::FILL_W'(count_nx)};
							end
						end else if (full) begin
							cur_byte_q <= head.cmd.data;
							drop_n_q   <= head.cmd.drop_n;
							state_q    <= S_DROP;
						end else begin
							out_valid_q <= 1'b1;
							out_q       <= '{8'h00, 1'b0, dropped_q,
								lrb_pkg::FILL_W'(count_nx)};
						end
					end
				end
				S_RD: begin
					out_valid_q <= 1'b1;
					out_q       <= '{rd_data_q, 1'b1, lat_lines_q,
						lrb_pkg::FILL_W'(count_q)};
					state_q     <= S_IDLE;
				end
				// drop the requested minimum, one byte a cycle
				S_DROP: begin
					if (rd_en) begin
						drop_n_q <= drop_n_q - 1'b1;
					end else begin
						state_q <= S_SCAN_ISSUE;
					end
				end
				// then drop through the next newline
				S_SCAN_ISSUE: begin
					state_q <= rd_en ? S_SCAN_CHECK : S_WR;
				end
				S_SCAN_CHECK: begin
					state_q <= is_nl ? S_WR : S_SCAN_ISSUE;
				end
				S_WR: begin
					out_valid_q <= 1'b1;
					out_q       <= '{8'h00, 1'b0, dropped_q,
						lrb_pkg::FILL_W'(count_nx)};
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid  = out_valid_q;
	assign rsp        = out_q;
	assign stat.count = count_q;
	assign stat.busy  = (state_q != S_IDLE);

endmodule

FILE: design/line_dropping_log_ring_buffer.sv
// line_dropping_log_ring_buffer: top level of the log ring buffer
// ties the request front end and the store back end together
// depends on lrb_pkg, lrb_front, lrb_back
//
// Usage:
//   Request channel (req_valid/req_stall/req): a write stores req.byte_in; a
//   read pops the oldest stored byte. Each request yields exactly one
//   response on rsp_valid/rsp_stall/rsp, in request order.
//   A write to a full store first discards the oldest bytes: req.bytes_left
//   of them (one if zero, fewer if the store empties), then on through the
//   next newline. Every dropped newline bumps the missing-lines count
//   (saturating), which a read reports and clears.
//   Timing: requests enter a two-entry queue; the back end takes one at a
//   time. A write to a non-full store or a read of an empty one answers in
//   the cycle after it leaves the queue; a read that finds data goes through
//   S_RD first (registered memory read). A write to a full store goes through
//   S_DROP, then S_SCAN_ISSUE and S_SCAN_CHECK for each scanned byte, then
//   S_WR, with one memory read per dropped byte. The back end takes no new
//   request until it is back in S_IDLE.
//   Reset clears pointers, fill and the counter; the store needs no clearing.
//   A stalled response holds its value and blocks the back end; requests
//   keep entering until the queue is full, then req_stall rises.
module line_dropping_log_ring_buffer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lrb_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lrb_pkg::rsp_t rsp
);

	lrb_pkg::qhead_t head;
	lrb_pkg::bstat_t stat;
	logic            pop;

	// request intake and queue
	lrb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.pop       (pop),
		.head      (head)
	);

	// store and drop sequencer
	lrb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.stat      (stat)
	);

	// fill never passes the ring size
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= lrb_pkg::CNT_W'(lrb_pkg::DEPTH))
		else $error("fill exceeds ring depth");

	// every back-end operation finishes with a response
	a_op_ends_in_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(stat.busy) |-> rsp_valid)
		else $error("operation finished without a response");

	// no popped byte means a zero data field
	a_empty_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.byte_valid |-> rsp.byte_out == 8'h00)
		else $error("byte_out set without byte_valid");

	// the back end only pulls from a non-empty queue while idle
	a_pop_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid && !stat.busy)
		else $error("queue popped while busy or empty");

endmodule

FILE: tb/line_dropping_log_ring_buffer_tb.sv
// line_dropping_log_ring_buffer_tb: self-checking bench for the log ring buffer
// predicts each response from a local copy of the ring and counters, drives random text
// depends on lrb_pkg and line_dropping_log_ring_buffer
`timescale 1ns / 1ps

module line_dropping_log_ring_buffer_tb;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int FULL_RUN_ITEMS = 940;

	// ring contents, pointers and missing-lines count as the block should hold them
	class log_ring_scoreboard;
		bit [7:0]       ring [lrb_pkg::DEPTH];
		int unsigned    head = 0;
		int unsigned    tail = 0;
		int unsigned    fill = 0;
		int unsigned    lines = 0;
		lrb_pkg::rsp_t  rsp_owed [$];
		int unsigned    errors = 0;

		// pop the oldest byte, count it if it closed a line
		function bit discard_oldest();
			bit [7:0] b;
			b = ring[head];
			head = (head + 1 == lrb_pkg::DEPTH) ? 0 : head + 1;
			fill--;
			if (b == lrb_pkg::NEWLINE_BYTE) begin
				if (lines < lrb_pkg::LINES_MAX)
					lines++;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		// apply one accepted request and queue the response it owes
		function void note_request(lrb_pkg::req_t r);
			lrb_pkg::rsp_t e;
			int unsigned   n;
			e = '0;
			if (r.kind == lrb_pkg::KIND_WRITE) begin
				n = (r.bytes_left == 0) ? 1 : r.bytes_left;
				// full store: drop by count, then on through the next newline
				if (fill >= lrb_pkg::DEPTH) begin
					if (n > fill)
						n = fill;
					repeat (n) void'(discard_oldest());
					while (fill > 0) begin
						if (discard_oldest())
							break;
					end
				end
				ring[tail] = r.byte_in;
				tail = (tail + 1 == lrb_pkg::DEPTH) ? 0 : tail + 1;
				fill++;
				e.lines_missing = lines[lrb_pkg::LINES_W-1:0];
			end else begin
				e.lines_missing = lines[lrb_pkg::LINES_W-1:0];
				lines = 0;
				if (fill > 0) begin
					e.byte_out = ring[head];
					e.byte_valid = 1'b1;
					head = (head + 1 == lrb_pkg::DEPTH) ? 0 : head + 1;
					fill--;
				end
			end
			e.fill_level = fill[lrb_pkg::FILL_W-1:0];
			rsp_owed.push_back(e);
		endfunction

		function int field_diff(string name, int unsigned want, int unsigned seen);
			if (want == seen)
				return 0;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
			return 1;
		endfunction

		// compare one accepted response with the oldest owed one
		function void check_rsp(lrb_pkg::rsp_t got);
			lrb_pkg::rsp_t e;
			if (rsp_owed.size() == 0) begin
				$display("%0t: unexpected response, expected none, got %p", $time, got);
				errors++;
				return;
			end
			e = rsp_owed.pop_front();
			errors += field_diff("byte_out", e.byte_out, got.byte_out);
			errors += field_diff("byte_valid", e.byte_valid, got.byte_valid);
			errors += field_diff("lines_missing", e.lines_missing, got.lines_missing);
			errors += field_diff("fill_level", e.fill_level, got.fill_level);
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	lrb_pkg::req_t req = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	lrb_pkg::rsp_t rsp;
	logic          quiet = 1'b0;
	int            cycle_count = 0;

	log_ring_scoreboard sb = new();

	line_dropping_log_ring_buffer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL line_dropping_log_ring_buffer");
			$finish;
		end
	end

	// response side: random stall, check every accepted response
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall)
				sb.check_rsp(rsp);
			rsp_stall <= !quiet && ($urandom_range(99) < 12);
		end
	end

	// present one request, hold it until taken, then note it
	task automatic send_request(lrb_pkg::req_t r);
		if (!quiet && $urandom_range(99) < 12) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_request(r);
	endtask

	task automatic write_byte(logic [7:0] b, logic [lrb_pkg::LEFT_W-1:0] left);
		lrb_pkg::req_t r;
		r.kind = lrb_pkg::KIND_WRITE;
		r.byte_in = b;
		r.bytes_left = left;
		send_request(r);
	endtask

	task automatic read_byte();
		lrb_pkg::req_t r;
		r.kind = lrb_pkg::KIND_READ;
		r.byte_in = 8'($urandom());
		r.bytes_left = 16'($urandom());
		send_request(r);
	endtask

	// log-like text: short lines of arbitrary bytes
	function automatic logic [7:0] text_byte();
		if ($urandom_range(11) == 0)
			return lrb_pkg::NEWLINE_BYTE;
		return 8'($urandom());
	endfunction

	// any drop count while there is room, mostly short ones on a full store
	function automatic logic [lrb_pkg::LEFT_W-1:0] pick_left();
		if (sb.fill < lrb_pkg::DEPTH)
			return 16'($urandom());
		if ($urandom_range(99) < 85)
			return 16'($urandom_range(1, 16));
		return 16'($urandom_range(17, 900));
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty read, field extremes, zero drop count
		read_byte();
		write_byte(8'h00, 16'd1);
		write_byte(8'hFF, 16'd0);
		write_byte(lrb_pkg::NEWLINE_BYTE, 16'hFFFF);
		write_byte(8'hA5, 16'h8000);
		write_byte(8'h5A, 16'h7FFF);
		repeat (6) read_byte();

		// mixed traffic, one stretch with no idling
		for (int i = 0; i < FULL_RUN_ITEMS; i++) begin
			quiet <= (i >= 300 && i < 520);
			if ($urandom_range(99) < 30)
				read_byte();
			else
				write_byte(text_byte(), pick_left());
		end
		quiet <= 1'b0;
		req_valid <= 1'b0;

		// drain, then watch for stray responses
		while (sb.rsp_owed.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS line_dropping_log_ring_buffer");
		else
			$display("FAIL line_dropping_log_ring_buffer");
		$finish;
	end

endmodule

FILE: line_dropping_log_ring_buffer.f
design/lrb_pkg.sv
design/lrb_front.sv
design/lrb_back.sv
design/line_dropping_log_ring_buffer.sv
tb/line_dropping_log_ring_buffer_tb.sv
